@@ hdl/brs_pkg.sv @@
package brs_pkg;

  localparam int BRS_WORD_COUNT = 1024;
  localparam int BRS_CNT_W      = 17;

  typedef enum logic [2:0] {
    OP_TEST_AND_SET = 3'd0,
    OP_TEST         = 3'd1,
    OP_CLEAR_ALL    = 3'd2,
    OP_FINALIZE     = 3'd3,
    OP_RANK         = 3'd4
  } brs_op_e;

  typedef struct packed {
    logic                 bit_before;
    logic [BRS_CNT_W-1:0] rank_value;
    logic [BRS_CNT_W-1:0] total_set;
  } brs_res_t;

  // pairwise adder tree, six levels
  function automatic logic [6:0] ones64(logic [63:0] v);
    logic [6:0] s [64];
    for (int i = 0; i < 64; i++) begin
      s[i] = {6'd0, v[i]};
    end
    for (int lvl = 0; lvl < 6; lvl++) begin
      for (int i = 0; i < (64 >> (lvl + 1)); i++) begin
        s[i] = s[2*i] + s[2*i+1];
      end
    end
    return s[0];
  endfunction

endpackage

@@ hdl/brs_req_if.sv @@
interface brs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [15:0] slot;

  modport source (output valid, output operation, output slot, input ready);
  modport sink (input valid, input operation, input slot, output ready);
endinterface

@@ hdl/brs_res_if.sv @@
interface brs_res_if;
  logic        valid;
  logic        ready;
  logic        bit_before;
  logic [16:0] rank_value;
  logic [16:0] total_set;

  modport source (output valid, output bit_before, output rank_value, output total_set,
                  input ready);
  modport sink (input valid, input bit_before, input rank_value, input total_set,
                output ready);
endinterface

@@ hdl/bitvector_rank_store_top.sv @@
// channel  dir  payload                                  beat
// req_i    in   operation[2:0], slot[15:0]               one request
// res_o    out  bit_before, rank_value[16:0], total_set  one result per request
//
// test, test-and-set, rank and unused codes: one read and one
//   execute/write-back step on the word store
// finalize: one word per cycle through the popcount unit
// clear-all: one word zeroed per cycle
// after reset a clearing pass zeroes both stores, no requests taken
// a result held in the output register does not block acceptance of the next request, only its result
module bitvector_rank_store_top import brs_pkg::*; #(
  parameter int WORD_COUNT = BRS_WORD_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  brs_req_if.sink     req_i,
  brs_res_if.source   res_o
);

  localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  logic                 bit_we, bit_re, dir_we, dir_re;
  logic [AW-1:0]        bit_waddr, bit_raddr, dir_waddr, dir_raddr;
  logic [63:0]          bit_wdata, bit_rdata;
  logic [BRS_CNT_W-1:0] dir_wdata, dir_rdata;
  logic                 seq_res_valid;
  brs_res_t             seq_res;
  logic                 out_v_q;
  brs_res_t             out_q;
  logic                 out_free;

  assign out_free = !out_v_q || res_o.ready;

  brs_seq #(.WORD_COUNT(WORD_COUNT)) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_i.valid),
    .req_operation_i (req_i.operation),
    .req_slot_i      (req_i.slot),
    .req_ready_o     (req_i.ready),
    .out_free_i      (out_free),
    .res_valid_o     (seq_res_valid),
    .res_o           (seq_res),
    .bit_we_o        (bit_we),
    .bit_waddr_o     (bit_waddr),
    .bit_wdata_o     (bit_wdata),
    .bit_re_o        (bit_re),
    .bit_raddr_o     (bit_raddr),
    .bit_rdata_i     (bit_rdata),
    .dir_we_o        (dir_we),
    .dir_waddr_o     (dir_waddr),
    .dir_wdata_o     (dir_wdata),
    .dir_re_o        (dir_re),
    .dir_raddr_o     (dir_raddr),
    .dir_rdata_i     (dir_rdata)
  );

  brs_ram #(.DEPTH(WORD_COUNT), .WIDTH(64)) u_bit_ram (
    .clk_i   (clk_i),
    .we_i    (bit_we),
    .waddr_i (bit_waddr),
    .wdata_i (bit_wdata),
    .re_i    (bit_re),
    .raddr_i (bit_raddr),
    .rdata_o (bit_rdata)
  );

  brs_ram #(.DEPTH(WORD_COUNT), .WIDTH(BRS_CNT_W)) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .re_i    (dir_re),
    .raddr_i (dir_raddr),
    .rdata_o (dir_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (seq_res_valid) begin
      out_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res_valid) begin
      out_q <= seq_res;
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.bit_before = out_q.bit_before;
  assign res_o.rank_value = out_q.rank_value;
  assign res_o.total_set  = out_q.total_set;

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while previous one in progress");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_res_valid |-> !out_v_q || res_o.ready)
    else $error("output register overwritten before beat taken");

  a_load_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_res_valid |-> !req_i.ready)
    else $error("result produced while idle");
`endif

endmodule

@@ hdl/brs_ram.sv @@
module brs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/brs_seq.sv @@
module brs_seq import brs_pkg::*; #(
  parameter int WORD_COUNT = BRS_WORD_COUNT,
  localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic [2:0]           req_operation_i,
  input  logic [15:0]          req_slot_i,
  output logic                 req_ready_o,
  input  logic                 out_free_i,
  output logic                 res_valid_o,
  output brs_res_t             res_o,
  output logic                 bit_we_o,
  output logic [AW-1:0]        bit_waddr_o,
  output logic [63:0]          bit_wdata_o,
  output logic                 bit_re_o,
  output logic [AW-1:0]        bit_raddr_o,
  input  logic [63:0]          bit_rdata_i,
  output logic                 dir_we_o,
  output logic [AW-1:0]        dir_waddr_o,
  output logic [BRS_CNT_W-1:0] dir_wdata_o,
  output logic                 dir_re_o,
  output logic [AW-1:0]        dir_raddr_o,
  input  logic [BRS_CNT_W-1:0] dir_rdata_i
);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_CLR  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [AW:0]          CNT_LAST  = (AW+1)'(WORD_COUNT - 1);
  localparam logic [AW:0]          CNT_END   = (AW+1)'(WORD_COUNT);
  localparam logic [AW-1:0]        IDX_LAST  = AW'(WORD_COUNT - 1);
  localparam logic [BRS_CNT_W-1:0] WORDS_LIM = BRS_CNT_W'(WORD_COUNT);

  logic [2:0]           st_q, st_d;
  logic [AW:0]          cnt_q, cnt_d;
  logic                 pv_q, pv_d;
  logic [AW-1:0]        pidx_q, pidx_d;
  logic [BRS_CNT_W-1:0] run_q, run_d;
  logic [BRS_CNT_W-1:0] tot_q, tot_d;
  logic [2:0]           op_q;
  logic [AW-1:0]        word_q;
  logic [5:0]           bpos_q;
  logic                 rng_q;
  logic                 bb_q, bb_d;
  logic [BRS_CNT_W-1:0] rank_q, rank_d;

  logic                 accept;
  logic                 slot_rng;
  logic                 cur_bb;
  logic [63:0]          bit_mask;
  logic [6:0]           low_ones;
  logic [6:0]           word_ones;
  logic [BRS_CNT_W-1:0] cur_rank;
  logic [BRS_CNT_W-1:0] run_next;

  assign accept    = req_valid_i && req_ready_o;
  assign slot_rng  = {7'd0, req_slot_i[15:6]} < WORDS_LIM;
  assign bit_mask  = 64'd1 << bpos_q;
  assign cur_bb    = rng_q & bit_rdata_i[bpos_q];
  assign low_ones  = ones64(bit_rdata_i & (bit_mask - 64'd1));
  assign word_ones = ones64(bit_rdata_i);
  assign run_next  = run_q + {10'd0, word_ones};
  assign cur_rank  = (op_q == OP_RANK && rng_q) ? dir_rdata_i + {10'd0, low_ones}
                                                : '0;

  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    run_d       = run_q;
    tot_d       = tot_q;
    bb_d        = bb_q;
    rank_d      = rank_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{bit_before: bb_q, rank_value: rank_q, total_set: tot_q};
    bit_we_o    = 1'b0;
    bit_waddr_o = cnt_q[AW-1:0];
    bit_wdata_o = '0;
    bit_re_o    = 1'b0;
    bit_raddr_o = AW'(req_slot_i[15:6]);
    dir_we_o    = 1'b0;
    dir_waddr_o = cnt_q[AW-1:0];
    dir_wdata_o = '0;
    dir_re_o    = 1'b0;
    dir_raddr_o = AW'(req_slot_i[15:6]);
    case (st_q)
      ST_INIT: begin
        bit_we_o = 1'b1;
        dir_we_o = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          bit_re_o = 1'b1;
          dir_re_o = 1'b1;
          st_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        bb_d   = cur_bb;
        rank_d = cur_rank;
        if (op_q == OP_TEST_AND_SET && rng_q) begin
          bit_we_o    = 1'b1;
          bit_waddr_o = word_q;
          bit_wdata_o = bit_rdata_i | bit_mask;
        end
        cnt_d = '0;
        run_d = '0;
        if (op_q == OP_CLEAR_ALL) begin
          st_d = ST_CLR;
        end else if (op_q == OP_FINALIZE) begin
          st_d = ST_FIN;
        end else if (out_free_i) begin
          res_valid_o = 1'b1;
          res_o       = '{bit_before: cur_bb, rank_value: cur_rank, total_set: tot_q};
          st_d        = ST_IDLE;
        end else begin
          st_d = ST_DONE;
        end
      end
      ST_CLR: begin
        bit_we_o = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          st_d = ST_DONE;
        end
      end
      ST_FIN: begin
        // read word n while counting word n-1
        if (cnt_q < CNT_END) begin
          bit_re_o    = 1'b1;
          bit_raddr_o = cnt_q[AW-1:0];
          pv_d        = 1'b1;
          pidx_d      = cnt_q[AW-1:0];
          cnt_d       = cnt_q + 1'b1;
        end
        if (pv_q) begin
          dir_we_o    = 1'b1;
          dir_waddr_o = pidx_q;
          dir_wdata_o = run_q;
          run_d       = run_next;
          if (pidx_q == IDX_LAST) begin
            tot_d = run_next;
            st_d  = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          st_d        = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_INIT;
      cnt_q <= '0;
      pv_q  <= 1'b0;
      tot_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      pv_q  <= pv_d;
      tot_q <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    run_q  <= run_d;
    bb_q   <= bb_d;
    rank_q <= rank_d;
    if (accept) begin
      op_q   <= req_operation_i;
      word_q <= AW'(req_slot_i[15:6]);
      bpos_q <= req_slot_i[5:0];
      rng_q  <= slot_rng;
    end
  end

endmodule

@@ tb/tb_bitvector_rank_store_top.sv @@
module tb_bitvector_rank_store_top import brs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  class rank_scoreboard;
    logic [63:0]          words [BRS_WORD_COUNT];
    logic [BRS_CNT_W-1:0] prefix [BRS_WORD_COUNT];
    logic [BRS_CNT_W-1:0] total;
    brs_res_t             pending [$];
    int                   errors;

    function new();
      foreach (words[w]) begin
        words[w]  = '0;
        prefix[w] = '0;
      end
      total  = '0;
      errors = 0;
    endfunction

    task report(string msg);
      if (errors < 40) begin
        $display("%0t mismatch: %s", $realtime, msg);
      end
      errors++;
    endtask

    // expected beat for one accepted request, state updated in order
    function void note_request(logic [2:0] op, logic [15:0] slot);
      brs_res_t    want;
      int unsigned word;
      int unsigned running;
      logic [5:0]  bitpos;
      logic [63:0] below;
      bit          in_range;
      word     = slot >> 6;
      bitpos   = slot[5:0];
      in_range = word < BRS_WORD_COUNT;
      below    = (64'd1 << bitpos) - 64'd1;
      want.bit_before = in_range ? words[word][bitpos] : 1'b0;
      want.rank_value = '0;
      case (op)
        OP_TEST_AND_SET: begin
          if (in_range) words[word][bitpos] = 1'b1;
        end
        OP_CLEAR_ALL: begin
          foreach (words[w]) words[w] = '0;
        end
        OP_FINALIZE: begin
          running = 0;
          foreach (words[w]) begin
            prefix[w] = running[BRS_CNT_W-1:0];
            running += $countones(words[w]);
          end
          total = running[BRS_CNT_W-1:0];
        end
        OP_RANK: begin
          if (in_range) begin
            want.rank_value = prefix[word] + BRS_CNT_W'($countones(words[word] & below));
          end
        end
        default: ;
      endcase
      want.total_set = total;
      pending.push_back(want);
    endfunction

    task check_result(logic b, logic [BRS_CNT_W-1:0] r, logic [BRS_CNT_W-1:0] t);
      brs_res_t want;
      if (pending.size() == 0) begin
        report($sformatf("result beat with none pending (bit %0b rank %0d total %0d)",
                         b, r, t));
        return;
      end
      want = pending.pop_front();
      if (b !== want.bit_before)
        report($sformatf("bit_before %0b, want %0b", b, want.bit_before));
      if (r !== want.rank_value)
        report($sformatf("rank_value %0d, want %0d", r, want.rank_value));
      if (t !== want.total_set)
        report($sformatf("total_set %0d, want %0d", t, want.total_set));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  brs_req_if req_if ();
  brs_res_if res_if ();

  bitvector_rank_store_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  rank_scoreboard sb = new();

  int gap_pct   = 0;
  int stall_pct = 0;
  int hold_len  = 0;
  int hold_cnt  = 0;
  int n_sent    = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random back-pressure plus long hold-offs on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        hold_cnt = hold_len;
        hold_len = 0;
      end
      if (hold_cnt > 0) begin
        res_if.ready <= 1'b0;
        hold_cnt--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready)
        sb.check_result(res_if.bit_before, res_if.rank_value, res_if.total_set);
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.operation, req_if.slot);
    end
  end

  task automatic send_req(input logic [2:0] op, input logic [15:0] slot);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.slot      <= slot;
    do @(posedge clk_i); while (!req_if.ready);
    n_sent++;
  endtask

  function automatic logic [15:0] pick_slot(input logic [15:0] base);
    if ($urandom_range(3) == 0) return 16'($urandom);
    return base + 16'($urandom_range(0, 1023));
  endfunction

  // sets around a region, finalize, then queries; a little noise mixed in
  task automatic run_phase(input int target);
    int          start;
    logic [15:0] base;
    start = n_sent;
    while (n_sent - start < target) begin
      base = 16'($urandom);
      if ($urandom_range(11) == 0) send_req(OP_CLEAR_ALL, 16'($urandom));
      repeat ($urandom_range(4, 30)) begin
        if ($urandom_range(9) < 2) send_req(OP_TEST, pick_slot(base));
        send_req(OP_TEST_AND_SET, pick_slot(base));
      end
      if ($urandom_range(9) == 0) send_req(OP_RANK, pick_slot(base));
      send_req(OP_FINALIZE, 16'($urandom));
      repeat ($urandom_range(5, 25)) begin
        case ($urandom_range(9))
          0:       send_req(3'($urandom_range(OP_UNUSED_HI)), 16'($urandom));
          1, 2:    send_req(OP_TEST, pick_slot(base));
          default: send_req(OP_RANK, pick_slot(base));
        endcase
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_TEST;
    req_if.slot      = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    send_req(OP_TEST, 16'h0000);
    send_req(OP_TEST, 16'hffff);
    send_req(OP_TEST_AND_SET, 16'h0000);
    send_req(OP_TEST_AND_SET, 16'h0000);
    send_req(OP_TEST_AND_SET, 16'hffff);
    send_req(OP_TEST_AND_SET, 16'd63);
    send_req(OP_TEST_AND_SET, 16'd64);
    send_req(OP_TEST, 16'd63);
    send_req(OP_RANK, 16'hffff);
    send_req(OP_FINALIZE, 16'h0000);
    send_req(OP_RANK, 16'd0);
    send_req(OP_RANK, 16'd63);
    send_req(OP_RANK, 16'd64);
    send_req(OP_RANK, 16'd65);
    send_req(OP_RANK, 16'hffff);
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++) begin
      send_req(3'(op), 16'd63);
    end
    send_req(OP_TEST_AND_SET, 16'd1000);
    send_req(OP_RANK, 16'd2000);
    send_req(OP_CLEAR_ALL, 16'haaaa);
    send_req(OP_TEST, 16'h0000);
    send_req(OP_RANK, 16'hffff);
    send_req(OP_FINALIZE, 16'h5555);
    send_req(OP_RANK, 16'hffff);

    // result side held off while requests keep coming
    hold_len = 300;
    repeat (60) begin
      send_req($urandom_range(1) ? OP_TEST : OP_TEST_AND_SET, 16'($urandom));
    end

    run_phase(455);
    gap_pct = 61;
    run_phase(455);
    gap_pct   = 0;
    stall_pct = 61;
    run_phase(455);
    gap_pct   = 28;
    stall_pct = 28;
    run_phase(455);

    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
